// ===== src/histogram_minmax_normalize_top_assert.svh =====
// Assertion macros used by the histogram top level.
`ifndef HISTOGRAM_MINMAX_NORMALIZE_TOP_ASSERT_SVH
`define HISTOGRAM_MINMAX_NORMALIZE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HMN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HMN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hmn_pkg.sv =====
// Types and constants of the histogram min/max normalize block.
`timescale 1ns / 1ps

package hmn_pkg;

  localparam int BIN_W = 32;
  localparam int IDX_W = 6;
  localparam int REQ_W = 2;
  localparam int ST_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_INC   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NORM  = 2'd3
  } req_t;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_SAT      = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO_MAX = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_RMW,
    S_SRD,
    S_SCMP,
    S_NRD,
    S_NDIV,
    S_NWAIT,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/hmn_bin_mem.sv =====
// Bin store: one write port, one registered read port.
`timescale 1ns / 1ps

module hmn_bin_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [hmn_pkg::BIN_W-1:0]   wdata,
  input  logic [AW-1:0]               raddr,
  output logic [hmn_pkg::BIN_W-1:0]   rdata
);

  logic [hmn_pkg::BIN_W-1:0] mem_r [DEPTH];
  logic [hmn_pkg::BIN_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/hmn_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module hmn_div #(
  parameter int DW = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [hmn_pkg::BIN_W-1:0]  divisor,
  output hmn_pkg::div_stat_t         stat,
  output logic [hmn_pkg::BIN_W-1:0]  quot
);

  localparam int CW = $clog2(DW + 1);
  localparam int BW = hmn_pkg::BIN_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dq_r, dq_nxt;
  logic [BW-1:0] dsr_r, dsr_nxt;

  logic [BW:0]   rem_sh;
  logic [BW+1:0] diff;
  logic          ge;

  assign rem_sh = {rem_r, dq_r[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign ge     = !diff[BW+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[BW-1:0] : rem_sh[BW-1:0];
      dq_nxt  = {dq_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dq_r[BW-1:0];

endmodule

// ===== src/histogram_minmax_normalize_top.sv =====
// Top level of the histogram store with min/max normalization.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | in_req_type[1:0], in_bin_index[5:0]
//  out      | out_valid / out_ready| out_bin_value[31:0], out_status[1:0]
//
//  Read and increment: accept, then the read-modify-write state S_RMW on
//  the bin memory's single read port.
//  Clear: one memory word written per cycle, over all NUM_BINS words.
//  Normalize: a min/max scan (S_SRD, S_SCMP for each bin), then for each
//  bin S_NRD, S_NDIV and S_NWAIT on the one-bit-per-cycle divider.
//  After reset a clearing pass over all NUM_BINS words runs before in_ready rises.
//  A finished transaction waits in the output register; the block goes back
//  to idle while it waits, and only stalls if a second result is ready first.

module histogram_minmax_normalize_top #(
  parameter int NUM_BINS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hmn_pkg::REQ_W-1:0]     in_req_type,
  input  logic [hmn_pkg::IDX_W-1:0]     in_bin_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hmn_pkg::BIN_W-1:0]     out_bin_value,
  output logic [hmn_pkg::ST_W-1:0]      out_status
);

`include "histogram_minmax_normalize_top_assert.svh"

  localparam int AW = $clog2(NUM_BINS);
  localparam int BW = hmn_pkg::BIN_W;
  localparam int DW = BW + FRAC_BITS;
  localparam logic [BW-1:0] ONE_FX  = BW'(1) << FRAC_BITS;
  localparam logic [BW-1:0] SAT_LIM = {BW{1'b1}} - ONE_FX;
  localparam logic [AW-1:0] LAST    = AW'(NUM_BINS - 1);

  hmn_pkg::state_t state_r, state_nxt;
  hmn_pkg::req_t   req_r, req_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic            rng_r, rng_nxt;
  logic            clr_req_r, clr_req_nxt;
  logic [BW-1:0]   min_r, min_nxt;
  logic [BW-1:0]   max_r, max_nxt;
  logic [BW-1:0]   res_val_r, res_val_nxt;
  logic [hmn_pkg::ST_W-1:0] res_st_r, res_st_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [BW-1:0]   out_val_r, out_val_nxt;
  logic [hmn_pkg::ST_W-1:0] out_st_r, out_st_nxt;

  // memory port
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [BW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [BW-1:0]   mem_rdata;

  // divider port
  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  hmn_pkg::div_stat_t   div_stat;
  logic [BW-1:0]        div_quot;

  logic            fin;
  logic [BW-1:0]   fin_val;
  logic [hmn_pkg::ST_W-1:0] fin_st;
  logic            slot_free;
  logic            in_rng;
  logic [BW-1:0]   scan_min, scan_max;
  logic [BW-1:0]   bin_diff;

  hmn_bin_mem #(
    .DEPTH (NUM_BINS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hmn_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (max_r),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  assign slot_free    = !out_valid_r || out_ready;
  assign in_rng       = 32'(in_bin_index) < 32'(NUM_BINS);
  assign scan_min     = (mem_rdata < min_r) ? mem_rdata : min_r;
  assign scan_max     = (mem_rdata > max_r) ? mem_rdata : max_r;
  assign bin_diff     = mem_rdata - min_r;
  assign div_dividend = DW'(bin_diff) << FRAC_BITS;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    rng_nxt       = rng_r;
    clr_req_nxt   = clr_req_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = '0;
    mem_raddr     = cnt_r;
    div_start     = 1'b0;
    fin           = 1'b0;
    fin_val       = '0;
    fin_st        = hmn_pkg::ST_OK;

    unique case (state_r)
      hmn_pkg::S_IDLE: begin
        mem_raddr = AW'(in_bin_index);
        if (in_valid) begin
          req_nxt     = hmn_pkg::req_t'(in_req_type);
          addr_nxt    = AW'(in_bin_index);
          rng_nxt     = in_rng;
          cnt_nxt     = '0;
          clr_req_nxt = 1'b0;
          unique case (hmn_pkg::req_t'(in_req_type))
            hmn_pkg::REQ_CLEAR: begin
              clr_req_nxt = 1'b1;
              state_nxt   = hmn_pkg::S_CLR;
            end
            hmn_pkg::REQ_INC, hmn_pkg::REQ_READ: state_nxt = hmn_pkg::S_RMW;
            hmn_pkg::REQ_NORM: begin
              min_nxt   = '1;
              max_nxt   = '0;
              state_nxt = hmn_pkg::S_SRD;
            end
            default: state_nxt = hmn_pkg::S_IDLE;
          endcase
        end
      end
      hmn_pkg::S_CLR: begin
        mem_we = 1'b1;
        if (cnt_r == LAST) begin
          if (clr_req_r) begin
            fin = 1'b1;
          end else begin
            state_nxt = hmn_pkg::S_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      hmn_pkg::S_RMW: begin
        mem_waddr = addr_r;
        fin       = 1'b1;
        if (rng_r) begin
          if (req_r == hmn_pkg::REQ_INC) begin
            mem_we = 1'b1;
            if (mem_rdata > SAT_LIM) begin
              mem_wdata = '1;
              fin_st    = hmn_pkg::ST_SAT;
            end else begin
              mem_wdata = mem_rdata + ONE_FX;
            end
            fin_val = mem_wdata;
          end else begin
            fin_val = mem_rdata;
          end
        end
      end
      hmn_pkg::S_SRD: state_nxt = hmn_pkg::S_SCMP;
      hmn_pkg::S_SCMP: begin
        min_nxt = scan_min;
        max_nxt = scan_max;
        if (cnt_r == LAST) begin
          cnt_nxt = '0;
          if (scan_max == '0) begin
            fin    = 1'b1;
            fin_st = hmn_pkg::ST_ZERO_MAX;
          end else begin
            state_nxt = hmn_pkg::S_NRD;
          end
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = hmn_pkg::S_SRD;
        end
      end
      hmn_pkg::S_NRD: state_nxt = hmn_pkg::S_NDIV;
      hmn_pkg::S_NDIV: begin
        div_start = 1'b1;
        state_nxt = hmn_pkg::S_NWAIT;
      end
      hmn_pkg::S_NWAIT: begin
        if (div_stat.done) begin
          mem_we    = 1'b1;
          mem_wdata = div_quot;
          if (cnt_r == LAST) begin
            fin = 1'b1;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = hmn_pkg::S_NRD;
          end
        end
      end
      hmn_pkg::S_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          state_nxt     = hmn_pkg::S_IDLE;
        end
      end
      default: state_nxt = hmn_pkg::S_IDLE;
    endcase

    // result goes straight out when the output register is free
    if (fin) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = fin_val;
        out_st_nxt    = fin_st;
        state_nxt     = hmn_pkg::S_IDLE;
      end else begin
        res_val_nxt = fin_val;
        res_st_nxt  = fin_st;
        state_nxt   = hmn_pkg::S_HOLD;
      end
    end
  end

  // reset starts the clearing pass over the bin memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hmn_pkg::S_CLR;
      cnt_r       <= '0;
      clr_req_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_req_r   <= clr_req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    addr_r    <= addr_nxt;
    rng_r     <= rng_nxt;
    min_r     <= min_nxt;
    max_r     <= max_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_ready      = (state_r == hmn_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_bin_value = out_val_r;
  assign out_status    = out_st_r;

  `HMN_ASSERT_IMP(a_no_write_idle, (state_r == hmn_pkg::S_IDLE || state_r == hmn_pkg::S_HOLD), !mem_we, "bin memory written while idle")
  `HMN_ASSERT_IMP(a_div_start_free, div_start, !div_stat.busy, "divider started while busy")
  `HMN_ASSERT_IMP(a_norm_bounds, state_r == hmn_pkg::S_NRD, (max_r != '0) && (min_r <= max_r), "normalize pass with bad min/max")
  `HMN_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state_r != hmn_pkg::S_IDLE, "accepted transaction left block idle")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the histogram min/max normalize block.
`timescale 1ns / 1ps

module testbench;
  import hmn_pkg::*;

  localparam int NUM_BINS  = 64;
  localparam int FRAC_BITS = 16;

  // Run control. A run has ~600 transactions, normalizes among them; the
  // cycle limit leaves a wide margin over what such a run takes.
  localparam int RANDOM_ITEMS    = 450;
  localparam int IDLE_PCT        = 18;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 50;
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int MAX_REPORTS     = 10;

  localparam logic [BIN_W-1:0] ONE_FX       = BIN_W'(1) << FRAC_BITS;
  localparam logic [BIN_W-1:0] BIN_ALL_ONES = {BIN_W{1'b1}};

  // One result transaction as it leaves the block.
  typedef struct packed {
    logic [BIN_W-1:0] value;
    logic [ST_W-1:0]  status;
  } hist_result_t;

  // Directed step: reps > 1 repeats the request; sweep walks the index
  // upward on each repeat. typed rows carry an expectation worked out by
  // hand, the rest go through the bin predictor.
  typedef struct {
    req_t             req;
    logic [IDX_W-1:0] idx;
    int unsigned      reps;
    bit               sweep;
    bit               typed;
    hist_result_t     want;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  dir_row_t directed_steps [DIR_ROWS] = '{
    // fresh out of reset: everything reads zero, normalize sees max == 0
    '{REQ_READ,  6'd0,  1,     1'b0, 1'b1, '{32'h0000_0000, ST_OK}},
    '{REQ_READ,  6'd63, 1,     1'b0, 1'b1, '{32'h0000_0000, ST_OK}},
    '{REQ_NORM,  6'd0,  1,     1'b0, 1'b1, '{32'h0000_0000, ST_ZERO_MAX}},
    // lowest and highest index, one and two counts
    '{REQ_INC,   6'd0,  1,     1'b0, 1'b1, '{32'h0001_0000, ST_OK}},
    '{REQ_INC,   6'd63, 1,     1'b0, 1'b1, '{32'h0001_0000, ST_OK}},
    '{REQ_INC,   6'd63, 1,     1'b0, 1'b1, '{32'h0002_0000, ST_OK}},
    // normalize with a fractional result in bin 0
    '{REQ_NORM,  6'd0,  1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_READ,  6'd0,  1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_READ,  6'd63, 1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_CLEAR, 6'd17, 1,     1'b0, 1'b1, '{32'h0000_0000, ST_OK}},
    '{REQ_READ,  6'd63, 1,     1'b0, 1'b1, '{32'h0000_0000, ST_OK}},
    // every bin equal and nonzero: min == max flattens everything to zero
    '{REQ_INC,   6'd0,  64,    1'b1, 1'b0, '{32'h0, ST_OK}},
    '{REQ_NORM,  6'd0,  1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_READ,  6'd21, 1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    // a middle bin two counts ahead
    '{REQ_INC,   6'd42, 2,     1'b0, 1'b0, '{32'h0, ST_OK}},
    // lift every bin so the minimum is nonzero, then normalize by max
    '{REQ_INC,   6'd0,  64,    1'b1, 1'b0, '{32'h0, ST_OK}},
    '{REQ_INC,   6'd5,  3,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_NORM,  6'd0,  1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_READ,  6'd42, 1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_READ,  6'd5,  1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_READ,  6'd0,  1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    // normalize of already normalized data
    '{REQ_NORM,  6'd0,  1,     1'b0, 1'b0, '{32'h0, ST_OK}},
    '{REQ_READ,  6'd5,  1,     1'b0, 1'b0, '{32'h0, ST_OK}}
  };

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic [REQ_W-1:0] in_req_type  = REQ_CLEAR;
  logic [IDX_W-1:0] in_bin_index = '0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic [BIN_W-1:0] out_bin_value;
  logic [ST_W-1:0]  out_status;

  // Predictor state: our own copy of the bin memory.
  logic [BIN_W-1:0] bin_model [NUM_BINS];

  // Results owed by the block, oldest first.
  hist_result_t     pending_results [$];

  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;

  // Shared between sender and receiver: calm_window turns idling off on
  // both sides; hold_off_req asks the receiver for one long stall.
  bit               calm_window    = 1'b0;
  bit               hold_off_req   = 1'b0;

  histogram_minmax_normalize_top #(
    .NUM_BINS  (NUM_BINS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_bin_index  (in_bin_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_value (out_bin_value),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one request to the bin model and returns the result it owes.
  function automatic hist_result_t predict_request(input req_t req,
                                                   input logic [IDX_W-1:0] idx);
    hist_result_t     res;
    logic [BIN_W-1:0] lo;
    logic [BIN_W-1:0] hi;
    logic [BIN_W-1:0] diff;
    logic [63:0]      scaled;
    res.value  = '0;
    res.status = ST_OK;
    case (req)
      REQ_CLEAR: begin
        foreach (bin_model[i]) bin_model[i] = '0;
      end
      REQ_INC: begin
        if (idx < NUM_BINS) begin
          if (bin_model[idx] > BIN_ALL_ONES - ONE_FX) begin
            bin_model[idx] = BIN_ALL_ONES;
            res.status     = ST_SAT;
          end else begin
            bin_model[idx] = bin_model[idx] + ONE_FX;
          end
          res.value = bin_model[idx];
        end
      end
      REQ_READ: begin
        if (idx < NUM_BINS) res.value = bin_model[idx];
      end
      default: begin
        // min/max scan, then (bin - min) scaled up and divided by max
        lo = bin_model[0];
        hi = bin_model[0];
        foreach (bin_model[i]) begin
          if (bin_model[i] < lo) lo = bin_model[i];
          if (bin_model[i] > hi) hi = bin_model[i];
        end
        if (hi == '0) begin
          res.status = ST_ZERO_MAX;
        end else begin
          foreach (bin_model[i]) begin
            diff         = bin_model[i] - lo;
            scaled       = {32'b0, diff} << FRAC_BITS;
            bin_model[i] = BIN_W'(scaled / {32'b0, hi});
          end
        end
      end
    endcase
    return res;
  endfunction

  // Offers one transaction, idling first at random. Called at a rising
  // edge; returns at the edge where the block accepted it.
  task automatic send_req(input req_t req, input logic [IDX_W-1:0] idx,
                          input bit typed, input hist_result_t want);
    hist_result_t predicted;
    while (!calm_window && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_bin_index <= idx;
    do @(posedge clk); while (!in_ready);
    // always run the predictor so the bin model tracks the block
    predicted = predict_request(req, idx);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Stimulus: reset, directed table, random traffic, then drain.
  initial begin
    int               row;
    int unsigned      rep;
    int unsigned      pick;
    req_t             req;
    logic [IDX_W-1:0] idx;

    foreach (bin_model[i]) bin_model[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // in_ready stays low through the post-reset clearing pass; the
    // handshake wait in send_req covers it.

    for (row = 0; row < DIR_ROWS; row++) begin
      for (rep = 0; rep < directed_steps[row].reps; rep++) begin
        idx = directed_steps[row].sweep ? IDX_W'(directed_steps[row].idx + rep)
                                        : directed_steps[row].idx;
        send_req(directed_steps[row].req, idx, directed_steps[row].typed,
                 directed_steps[row].want);
      end
    end

    // Random traffic: mostly increments and reads on a handful of bins so
    // counts build up, occasional clears and normalizes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_off_req = 1'b1;
      calm_window = (n >= 250) && (n < 400);
      pick = $urandom_range(99);
      if (pick < 4)       req = REQ_CLEAR;
      else if (pick < 7)  req = REQ_NORM;
      else if (pick < 62) req = REQ_INC;
      else                req = REQ_READ;
      idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(NUM_BINS - 1))
                                     : IDX_W'($urandom_range(7));
      send_req(req, idx, 1'b0, '0);
    end
    calm_window = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // nothing should be in flight now; watch for stray results a while
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off so the
  // output register fills, the next result backs up and in_ready drops.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= calm_window || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    hist_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0d] unexpected result: value=%h status=%0d",
                   cycle_count, out_bin_value, out_status);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_bin_value !== want.value || out_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0d] mismatch: value exp=%h got=%h, status exp=%0d got=%0d",
                     cycle_count, want.value, out_bin_value, want.status,
                     out_status);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== histogram_minmax_normalize_top.f =====
+incdir+src
src/hmn_pkg.sv
src/hmn_bin_mem.sv
src/hmn_div.sv
src/histogram_minmax_normalize_top.sv
bench/testbench.sv
